/* src/lss_pkg.sv */
package lss_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_PATTERN_DEF = 8;
    localparam int INDEX_BITS_DEF  = 32;

    // Result fields leave the block at a fixed width.
    localparam int OUT_W = 32;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_CASE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ONLY     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BINARY_MODE    = 3'd4;

    // Line break characters.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_FF = 8'h0C;

    // Result kinds.
    localparam logic KIND_MATCH    = 1'b0;
    localparam logic KIND_LINE_END = 1'b1;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Everything one accepted byte leaves for the back: up to one match
    // result followed by up to one line-end result.
    typedef struct packed {
        logic             valid;
        logic             has_match;
        logic [OUT_W-1:0] match_index;
        logic [OUT_W-1:0] row_number;
        logic [OUT_W-1:0] column_number;
        logic [OUT_W-1:0] line_start_index;
        logic             has_end;
        logic [OUT_W-1:0] line_end_index;
        logic             final_flag;
    } t_event;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

endpackage

/* src/lss_front.sv */
module lss_front #(
    parameter int MAX_PATTERN = lss_pkg::MAX_PATTERN_DEF,
    parameter int INDEX_BITS  = lss_pkg::INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_byte,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lss_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_queue_full,
    output lss_pkg::t_event                  o_push
);
    import lss_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int AGE_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    // Configuration registers.
    logic [63:0] r_pattern;
    logic [3:0]  r_plen;
    logic        r_icase;
    logic        r_first;
    logic        r_bin;

    // Stream state.
    logic [7:0]            r_win  [MAX_PATTERN];
    logic [INDEX_BITS-1:0] r_hrow [MAX_PATTERN];
    logic [INDEX_BITS-1:0] r_hcol [MAX_PATTERN];
    logic [INDEX_BITS-1:0] r_hls  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_hbrk;
    logic [LEN_W-1:0]      r_fill;
    logic [INDEX_BITS-1:0] r_count;
    logic [INDEX_BITS-1:0] r_row;
    logic [INDEX_BITS-1:0] r_col;
    logic [INDEX_BITS-1:0] r_ls;
    logic                  r_prev_cr;
    logic                  r_pending;
    logic                  r_done;

    logic [7:0]            w_next   [MAX_PATTERN];
    logic [INDEX_BITS-1:0] row_age  [MAX_PATTERN];
    logic [INDEX_BITS-1:0] col_age  [MAX_PATTERN];
    logic [INDEX_BITS-1:0] ls_age   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] brk_age;

    logic                  accept;
    logic                  brk;
    logic [LEN_W-1:0]      len;
    logic [AGE_W-1:0]      start_age;
    logic [LEN_W-1:0]      n_fill;
    logic [INDEX_BITS-1:0] n_row;
    logic [INDEX_BITS-1:0] n_col;
    logic [INDEX_BITS-1:0] n_ls;
    logic                  n_pending;
    logic                  n_done;
    logic                  eq;
    logic                  matched;
    logic                  end_found;
    logic [INDEX_BITS-1:0] end_index;
    logic [INDEX_BITS-1:0] start_index;

    assign accept      = i_in_valid && !i_queue_full;
    assign o_in_stall  = i_queue_full;
    assign o_cfg_ready = 1'b1;

    assign brk = (i_data_byte == CH_CR) || (i_data_byte == CH_LF) || (i_data_byte == CH_FF);

    // Line tracking for the current byte.
    always_comb begin
        if (brk) begin
            n_row = (i_data_byte == CH_LF && r_prev_cr) ? r_row : r_row + 1'b1;
            n_col = '0;
            n_ls  = r_count + 1'b1;
        end else begin
            n_row = r_row;
            n_col = r_col + 1'b1;
            n_ls  = r_ls;
        end
    end

    // Per-age views: age 0 is the current byte, older ones come from registers.
    always_comb begin
        w_next[0]  = i_data_byte;
        row_age[0] = brk ? '0 : r_row;
        col_age[0] = brk ? '0 : n_col;
        ls_age[0]  = brk ? '0 : r_ls;
        brk_age[0] = brk;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            w_next[k]  = r_win[k-1];
            row_age[k] = r_hrow[k-1];
            col_age[k] = r_hcol[k-1];
            ls_age[k]  = r_hls[k-1];
            brk_age[k] = r_hbrk[k-1];
        end
    end

    always_comb begin
        if (r_plen == 4'd0) begin
            len = LEN_W'(1);
        end else if (r_plen > 4'(MAX_PATTERN)) begin
            len = MAX_LEN;
        end else begin
            len = LEN_W'(r_plen);
        end
    end

    assign start_age   = AGE_W'(len - LEN_W'(1));
    assign start_index = r_count - INDEX_BITS'(len - LEN_W'(1));
    assign n_fill      = (r_fill < MAX_LEN) ? r_fill + LEN_W'(1) : r_fill;

    // Parallel compare of the window against the pattern.
    always_comb begin
        logic [7:0] pb;
        logic [7:0] db;
        eq = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pb = r_pattern[8*j +: 8];
            db = w_next[AGE_W'(len - LEN_W'(j) - LEN_W'(1))];
            if (r_icase) begin
                pb = fold_lower(pb);
                db = fold_lower(db);
            end
            if (LEN_W'(j) < len && pb != db) begin
                eq = 1'b0;
            end
        end
    end

    assign matched = !r_done && (n_fill >= len) && eq && (r_bin || !brk_age[start_age]);
    assign n_done  = r_done || (matched && r_first);

    // Line end of the latest match line.
    always_comb begin
        logic             pend;
        logic             in_match;
        logic [AGE_W-1:0] dsel;
        pend     = r_pending || (matched && !r_bin);
        in_match = 1'b0;
        dsel     = '0;
        // Oldest break inside the match that follows its start.
        for (int d = 0; d < MAX_PATTERN - 1; d++) begin
            if (LEN_W'(d + 1) < len && brk_age[d]) begin
                in_match = 1'b1;
                dsel     = AGE_W'(d);
            end
        end
        end_found = 1'b0;
        end_index = '0;
        if (!r_bin && pend) begin
            if (matched && in_match) begin
                end_found = 1'b1;
                end_index = r_count - INDEX_BITS'(dsel);
            end else if (!matched && brk) begin
                end_found = 1'b1;
                end_index = r_count;
            end else if (i_last_byte) begin
                end_found = 1'b1;
                end_index = r_count + 1'b1;
            end
        end
        n_pending = pend && !end_found && !r_bin;
    end

    always_comb begin
        o_push.valid            = accept && (matched || end_found);
        o_push.has_match        = matched;
        o_push.match_index      = OUT_W'(start_index);
        o_push.row_number       = r_bin ? '0 : OUT_W'(row_age[start_age]);
        o_push.column_number    = r_bin ? '0 : OUT_W'(col_age[start_age]);
        o_push.line_start_index = r_bin ? '0 : OUT_W'(ls_age[start_age]);
        o_push.has_end          = end_found;
        o_push.line_end_index   = OUT_W'(end_index);
        o_push.final_flag       = i_last_byte || (n_done && !n_pending);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= 4'd1;
            r_icase   <= 1'b0;
            r_first   <= 1'b0;
            r_bin     <= 1'b0;
            r_hbrk    <= '0;
            r_fill    <= '0;
            r_count   <= '0;
            r_row     <= INDEX_BITS'(1);
            r_col     <= '0;
            r_ls      <= '0;
            r_prev_cr <= 1'b0;
            r_pending <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PATTERN_BYTES:  r_pattern <= i_cfg_data;
                    REG_PATTERN_LENGTH: r_plen    <= i_cfg_data[3:0];
                    REG_IGNORE_CASE:    r_icase   <= i_cfg_data[0];
                    REG_FIRST_ONLY:     r_first   <= i_cfg_data[0];
                    REG_BINARY_MODE:    r_bin     <= i_cfg_data[0];
                    default:            ;
                endcase
            end
            if (accept) begin
                if (i_last_byte) begin
                    r_hbrk    <= '0;
                    r_fill    <= '0;
                    r_count   <= '0;
                    r_row     <= INDEX_BITS'(1);
                    r_col     <= '0;
                    r_ls      <= '0;
                    r_prev_cr <= 1'b0;
                    r_pending <= 1'b0;
                    r_done    <= 1'b0;
                end else begin
                    r_hbrk    <= brk_age;
                    r_fill    <= n_fill;
                    r_count   <= r_count + 1'b1;
                    r_row     <= n_row;
                    r_col     <= n_col;
                    r_ls      <= n_ls;
                    r_prev_cr <= (i_data_byte == CH_CR);
                    r_pending <= n_pending;
                    r_done    <= n_done;
                end
            end
        end
    end

    // Window and history payload; only read once the fill count covers them.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win  <= w_next;
            r_hrow <= row_age;
            r_hcol <= col_age;
            r_hls  <= ls_age;
        end
    end

endmodule

/* src/lss_queue.sv */
module lss_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lss_pkg::t_event i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lss_pkg::t_event o_head
);
    import lss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_event             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push;
        end
    end

    a_count_matches_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == PTR_W'(r_count))
        else $error("queue count disagrees with pointers");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !do_push)
        else $error("queue written while full");

endmodule

/* src/lss_back.sv */
module lss_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lss_pkg::t_event             i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_result_kind,
    output logic [lss_pkg::OUT_W-1:0]   o_match_index,
    output logic [lss_pkg::OUT_W-1:0]   o_row_number,
    output logic [lss_pkg::OUT_W-1:0]   o_column_number,
    output logic [lss_pkg::OUT_W-1:0]   o_line_start_index,
    output logic [lss_pkg::OUT_W-1:0]   o_line_end_index,
    output logic                        o_final_result
);
    import lss_pkg::*;

    // Set while the match of the head request has gone and its line end is shown.
    logic r_phase;
    logic cur_is_end;
    logic last_of_event;
    logic out_acc;

    assign cur_is_end    = r_phase || !i_head.has_match;
    assign last_of_event = cur_is_end || !i_head.has_end;
    assign o_out_valid   = !i_empty;
    assign out_acc       = o_out_valid && !i_out_stall;
    assign o_pop         = out_acc && last_of_event;

    always_comb begin
        o_result_kind      = cur_is_end ? KIND_LINE_END : KIND_MATCH;
        o_match_index      = cur_is_end ? '0 : i_head.match_index;
        o_row_number       = cur_is_end ? '0 : i_head.row_number;
        o_column_number    = cur_is_end ? '0 : i_head.column_number;
        o_line_start_index = cur_is_end ? '0 : i_head.line_start_index;
        o_line_end_index   = cur_is_end ? i_head.line_end_index : '0;
        o_final_result     = i_head.final_flag && last_of_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (out_acc) begin
            r_phase <= !last_of_event;
        end
    end

    a_phase_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!i_empty && i_head.has_match && i_head.has_end))
        else $error("line-end phase without a paired request");

    a_end_follows_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !last_of_event) |=> (o_out_valid && o_result_kind == KIND_LINE_END))
        else $error("line end did not follow its match");

    a_final_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_final_result) |-> o_pop || i_out_stall)
        else $error("final result not the last of its request");

endmodule

/* src/line_aware_substring_search.sv */
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_data_byte, i_last_byte
// result    out        o_out_valid / i_out_stall    o_result_kind .. o_final_result
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One data byte is taken per cycle while the queue is not full. A byte is
// classified, compared against the pattern and its line counters updated in
// the cycle it is accepted; the results it causes enter a four-entry queue and
// leave one per cycle unless the receiver stalls, so a byte that causes a match
// and a line end presents the match first and the line end after it. The
// input stalls only while the queue is full. Reset is synchronous and active
// low; it restores the registers to their defaults and starts a new search.
module line_aware_substring_search #(
    parameter int MAX_PATTERN = lss_pkg::MAX_PATTERN_DEF,
    parameter int INDEX_BITS  = lss_pkg::INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_result_kind,
    output logic [lss_pkg::OUT_W-1:0]        o_match_index,
    output logic [lss_pkg::OUT_W-1:0]        o_row_number,
    output logic [lss_pkg::OUT_W-1:0]        o_column_number,
    output logic [lss_pkg::OUT_W-1:0]        o_line_start_index,
    output logic [lss_pkg::OUT_W-1:0]        o_line_end_index,
    output logic                             o_final_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lss_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lss_pkg::*;

    // The front owns the configuration and all stream state. Each request it
    // pushes holds the results of one byte: an optional match followed by an
    // optional line end, with the final marking already worked out.
    t_event push;
    t_event head;
    logic   full;
    logic   empty;
    logic   pop;

    lss_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .INDEX_BITS  (INDEX_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (full),
        .o_push       (push)
    );

    // The queue decouples the two sides: the front keeps accepting bytes while
    // a result waits for the consumer, until the queue is full.
    lss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // The back splits each request into its results and presents them in order.
    lss_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (head),
        .i_empty            (empty),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_match_index      (o_match_index),
        .o_row_number       (o_row_number),
        .o_column_number    (o_column_number),
        .o_line_start_index (o_line_start_index),
        .o_line_end_index   (o_line_end_index),
        .o_final_result     (o_final_result)
    );

endmodule

/* tb/lss_checker.sv */
`timescale 1ns / 100ps

// Watches the byte, result and register channels of the search block. It keeps
// its own model of the search and compares every result with the oldest one
// still awaited.
module lss_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_result_kind,
    input  logic [lss_pkg::OUT_W-1:0]       i_match_index,
    input  logic [lss_pkg::OUT_W-1:0]       i_row_number,
    input  logic [lss_pkg::OUT_W-1:0]       i_column_number,
    input  logic [lss_pkg::OUT_W-1:0]       i_line_start_index,
    input  logic [lss_pkg::OUT_W-1:0]       i_line_end_index,
    input  logic                            i_final_result,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [lss_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import lss_pkg::*;

    typedef struct {
        logic        kind;
        logic [31:0] match_index;
        logic [31:0] row;
        logic [31:0] column;
        logic [31:0] line_start;
        logic [31:0] line_end;
        logic        final_flag;
    } t_search_result;

    t_search_result awaited_results[$];
    int             mismatches;

    // Register copies.
    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    bit          fold_case;
    bit          stop_first;
    bit          bin_mode;

    // Search state.
    logic [63:0] window;
    int          win_fill;
    logic [31:0] hist_row [8];
    logic [31:0] hist_col [8];
    logic [31:0] hist_ls  [8];
    bit          hist_brk [8];
    logic [31:0] byte_idx;
    logic [31:0] cur_row;
    logic [31:0] cur_col;
    logic [31:0] cur_ls;
    bit          prev_cr;
    bit          end_pending;
    bit          done;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c | 8'h20 : c;
    endfunction

    function automatic void clear_search();
        window      = '0;
        win_fill    = 0;
        for (int k = 0; k < 8; k++) begin
            hist_row[k] = '0;
            hist_col[k] = '0;
            hist_ls[k]  = '0;
            hist_brk[k] = 1'b0;
        end
        byte_idx    = '0;
        cur_row     = 32'd1;
        cur_col     = '0;
        cur_ls      = '0;
        prev_cr     = 1'b0;
        end_pending = 1'b0;
        done        = 1'b0;
    endfunction

    function automatic void write_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PATTERN_BYTES:  pat_bytes  = data;
            REG_PATTERN_LENGTH: pat_len    = data[3:0];
            REG_IGNORE_CASE:    fold_case  = data[0];
            REG_FIRST_ONLY:     stop_first = data[0];
            REG_BINARY_MODE:    bin_mode   = data[0];
            default: ;
        endcase
    endfunction

    // Advances the search by one byte and queues the results it causes.
    function automatic void search_byte(input logic [7:0] b, input logic last);
        logic [31:0]    i;
        logic [31:0]    s;
        logic [31:0]    probe;
        logic [31:0]    end_idx;
        logic [7:0]     p;
        logic [7:0]     d;
        int             len;
        int             n;
        int             j;
        int             back;
        bit             brk;
        bit             matched;
        bit             equal;
        bit             found;
        t_search_result res [2];

        i       = byte_idx;
        brk     = (b == CH_CR) || (b == CH_LF) || (b == CH_FF);
        len     = pat_len;
        matched = 1'b0;
        n       = 0;
        if (len < 1) len = 1;
        if (len > MAX_PATTERN_DEF) len = MAX_PATTERN_DEF;

        hist_brk[i[2:0]] = brk;
        if (brk) begin
            if (!(b == CH_LF && prev_cr)) cur_row = cur_row + 1;
            cur_col = '0;
            cur_ls  = i + 1;
            hist_row[i[2:0]] = '0;
            hist_col[i[2:0]] = '0;
            hist_ls[i[2:0]]  = '0;
        end else begin
            cur_col = cur_col + 1;
            hist_row[i[2:0]] = cur_row;
            hist_col[i[2:0]] = cur_col;
            hist_ls[i[2:0]]  = cur_ls;
        end
        prev_cr = (b == CH_CR);

        window = {window[55:0], b};
        if (win_fill < MAX_PATTERN_DEF) win_fill++;

        if (!done && win_fill >= len) begin
            equal = 1'b1;
            for (j = 0; j < len; j++) begin
                p = pat_bytes[8*j +: 8];
                d = window[8*(len-1-j) +: 8];
                if (fold_case) begin
                    p = lower_ascii(p);
                    d = lower_ascii(d);
                end
                if (p != d) equal = 1'b0;
            end
            if (equal) begin
                s = i - (len - 1);
                if (bin_mode) begin
                    res[n] = '{KIND_MATCH, s, '0, '0, '0, '0, 1'b0};
                    n++;
                    matched = 1'b1;
                end else if (!hist_brk[s[2:0]]) begin
                    res[n] = '{KIND_MATCH, s, hist_row[s[2:0]], hist_col[s[2:0]],
                               hist_ls[s[2:0]], '0, 1'b0};
                    n++;
                    end_pending = 1'b1;
                    matched     = 1'b1;
                end
                if (matched && stop_first) done = 1'b1;
            end
        end

        if (!bin_mode && end_pending) begin
            found   = 1'b0;
            end_idx = '0;
            if (matched) begin
                // The first break after the match start may sit inside the match.
                for (back = len - 2; back >= 0; back--) begin
                    probe = i - back;
                    if (hist_brk[probe[2:0]]) begin
                        found   = 1'b1;
                        end_idx = probe;
                        break;
                    end
                end
            end else if (brk) begin
                found   = 1'b1;
                end_idx = i;
            end
            if (!found && last) begin
                found   = 1'b1;
                end_idx = i + 1;
            end
            if (found) begin
                res[n] = '{KIND_LINE_END, '0, '0, '0, '0, end_idx, 1'b0};
                n++;
                end_pending = 1'b0;
            end
        end
        if (bin_mode) end_pending = 1'b0;

        byte_idx = i + 1;

        if (n > 0 && (last || (done && !end_pending))) res[n-1].final_flag = 1'b1;
        for (j = 0; j < n; j++) awaited_results.push_back(res[j]);

        if (last) clear_search();
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp,
                                          input logic [31:0] act);
        if (act !== exp) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        t_search_result exp;

        if (awaited_results.size() == 0) begin
            $error("result with nothing awaited: kind %0d index %0h end %0h",
                   i_result_kind, i_match_index, i_line_end_index);
            mismatches++;
            return;
        end
        exp = awaited_results.pop_front();
        compare_field("result_kind", exp.kind, i_result_kind);
        compare_field("match_index", exp.match_index, i_match_index);
        compare_field("row_number", exp.row, i_row_number);
        compare_field("column_number", exp.column, i_column_number);
        compare_field("line_start_index", exp.line_start, i_line_start_index);
        compare_field("line_end_index", exp.line_end, i_line_end_index);
        compare_field("final_result", exp.final_flag, i_final_result);
    endfunction

    initial begin
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_bytes  = '0;
            pat_len    = 4'd1;
            fold_case  = 1'b0;
            stop_first = 1'b0;
            bin_mode   = 1'b0;
            clear_search();
            awaited_results.delete();
        end else begin
            // A result leaving now belongs to an earlier byte, so it is
            // checked before the byte taken at this edge is modeled.
            if (i_out_valid && !i_out_stall) check_result();
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall) search_byte(i_data_byte, i_last_byte);
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the line-aware substring search. The checker next to
// the block does all prediction and comparison; this module only produces
// requests, configures the block between phases and decides the outcome.
module tb_top;
    import lss_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [7:0]             i_data_byte;
    logic                   i_last_byte;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_result_kind;
    logic [OUT_W-1:0]       o_match_index;
    logic [OUT_W-1:0]       o_row_number;
    logic [OUT_W-1:0]       o_column_number;
    logic [OUT_W-1:0]       o_line_start_index;
    logic [OUT_W-1:0]       o_line_end_index;
    logic                   o_final_result;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;

    // Idle percentages for the sender and the receiver in the current phase.
    int send_pct;
    int stall_pct;

    // The stimulus asks for a long receiver hold-off by bumping the request
    // count; the stall process notices the change and owns the countdown.
    int hold_requests;
    int hold_served;
    int hold_left;

    // Copy of the pattern setup, used only to shape byte streams that match.
    logic [63:0] cur_pattern;
    logic [3:0]  cur_len;
    bit          cur_fold;

    line_aware_substring_search DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_match_index      (o_match_index),
        .o_row_number       (o_row_number),
        .o_column_number    (o_column_number),
        .o_line_start_index (o_line_start_index),
        .o_line_end_index   (o_line_end_index),
        .o_final_result     (o_final_result),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    lss_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_result_kind      (o_result_kind),
        .i_match_index      (o_match_index),
        .i_row_number       (o_row_number),
        .i_column_number    (o_column_number),
        .i_line_start_index (o_line_start_index),
        .i_line_end_index   (o_line_end_index),
        .i_final_result     (o_final_result),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard limit on the run. Even the slowest legal run needs only a small
    // fraction of this.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver side. Outside a hold-off the stall is drawn each cycle from the
    // current phase's percentage. A hold-off keeps the stall up until its countdown
    // runs out, so the result queue fills and the block has to stall its input.
    initial begin
        i_out_stall = 1'b0;
        hold_served = 0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Phases: no idling, sender idle, receiver stalling, and both lightly.
    task automatic set_idling(input int phase);
        case (phase)
            0: begin send_pct = 0;  stall_pct = 0;  end
            1: begin send_pct = 54; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 54; end
            default: begin send_pct = 7; stall_pct = 7; end
        endcase
    endtask

    // Offers one byte request and returns at the falling edge after it was
    // taken. Random idle cycles may come first. Entered at a falling edge.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = data;
        i_last_byte = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input logic [7:0] seq[$], input bit terminate);
        foreach (seq[k]) send_byte(seq[k], terminate && (k == seq.size() - 1));
    endtask

    // Waits until every awaited result is out, then keeps the input idle for a
    // settling margin.
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [63:0] pattern, input logic [3:0] len,
                             input bit fold, input bit first, input bit binary);
        settle();
        write_reg(REG_PATTERN_BYTES, pattern);
        write_reg(REG_PATTERN_LENGTH, {60'd0, len});
        write_reg(REG_IGNORE_CASE, {63'd0, fold});
        write_reg(REG_FIRST_ONLY, {63'd0, first});
        write_reg(REG_BINARY_MODE, {63'd0, binary});
        cur_pattern = pattern;
        cur_len     = len;
        cur_fold    = fold;
    endtask

    // Patterns drawn from a small alphabet, with breaks and arbitrary bytes now
    // and then, so that random text hits them often.
    function automatic logic [63:0] random_pattern();
        logic [63:0] pat;
        for (int j = 0; j < 8; j++) begin
            case ($urandom_range(7))
                0, 1:    pat[8*j +: 8] = "a";
                2:       pat[8*j +: 8] = "b";
                3:       pat[8*j +: 8] = "A";
                4:       pat[8*j +: 8] = "B";
                5:       pat[8*j +: 8] = CH_LF;
                6:       pat[8*j +: 8] = CH_CR;
                default: pat[8*j +: 8] = 8'($urandom_range(255));
            endcase
        end
        return pat;
    endfunction

    // Sends n bytes of text built mostly from copies of the pattern (letter
    // case flipped at random when case folding is on), breaks of every kind,
    // pattern bytes, letters and arbitrary bytes. Copies cut off by the end of
    // the stream serve as broken matches. With terminate set the last byte
    // closes the data.
    task automatic send_stream(input int n, input bit terminate);
        logic [7:0] frag[$];
        logic [7:0] c;
        int         k;
        int         len;

        k   = 0;
        len = (cur_len == 0) ? 1 : (cur_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : cur_len;
        while (k < n) begin
            frag.delete();
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    for (int j = 0; j < len; j++) begin
                        c = cur_pattern[8*j +: 8];
                        if (cur_fold && (((c | 8'h20) >= "a") && ((c | 8'h20) <= "z"))
                            && $urandom_range(1))
                            c = c ^ 8'h20;
                        frag.push_back(c);
                    end
                end
                4: frag.push_back(CH_CR);
                5: frag.push_back(CH_LF);
                6: frag.push_back(CH_FF);
                7: begin
                    frag.push_back(CH_CR);
                    frag.push_back(CH_LF);
                end
                8: begin
                    if ($urandom_range(1))
                        frag.push_back(cur_pattern[8*$urandom_range(len - 1) +: 8]);
                    else
                        frag.push_back(8'($urandom_range(1) ? $urandom_range("a", "z")
                                                            : $urandom_range("A", "Z")));
                end
                default: frag.push_back(8'($urandom_range(255)));
            endcase
            foreach (frag[f]) begin
                if (k < n) begin
                    send_byte(frag[f], terminate && (k == n - 1));
                    k++;
                end
            end
        end
    endtask

    initial begin
        logic [7:0]  seq[$];
        logic [63:0] pat;
        logic [3:0]  len;
        int          items;
        int          n;
        int          waited;

        // Every input is known from time zero.
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_last_byte   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        hold_requests = 0;
        cur_pattern   = '0;
        cur_len       = 4'd1;
        cur_fold      = 1'b0;
        set_idling(0);

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // With the reset setup the pattern is a single zero byte: a lone zero
        // byte ending the data is both a match and the end of its line.
        send_byte(8'h00, 1'b1);

        // A pattern with a line feed in its middle, compared without case.
        // Each match carries its line end in the same step because the break
        // inside it ends the line. CR LF between the two counts as one break,
        // and the data ends on an all-ones byte after a form feed.
        configure({40'd0, "y", CH_LF, "x"}, 4'd3, 1'b1, 1'b0, 1'b0);
        seq = '{"X", CH_LF, "Y", CH_CR, CH_LF, "x", CH_LF, "y", CH_FF, 8'hFF};
        send_bytes(seq, 1'b1);

        // Length above the maximum acts as eight bytes: three bytes of data
        // cannot match, and the data ends without any result.
        configure("hgfedcba", 4'd15, 1'b0, 1'b1, 1'b0);
        seq = '{"a", "b", "c"};
        send_bytes(seq, 1'b1);

        // First-only: the second match is suppressed. Switching to binary mode
        // mid-stream drops the line end still awaited for the first match.
        configure({56'd0, "q"}, 4'd1, 1'b0, 1'b1, 1'b0);
        seq = '{"q", "q"};
        send_bytes(seq, 1'b0);
        settle();
        write_reg(REG_BINARY_MODE, 64'd1);
        seq = '{CH_LF, "q"};
        send_bytes(seq, 1'b1);

        // Length zero acts as one; binary mode reports indexes only.
        configure({56'd0, 8'hFF}, 4'd0, 1'b0, 1'b0, 1'b1);
        seq = '{8'hFF, CH_LF, 8'hFF};
        send_bytes(seq, 1'b1);

        // Long receiver hold-off while the sender keeps offering matching
        // bytes without a gap, so the result queue fills and input stalls.
        configure({56'd0, "a"}, 4'd1, 1'b0, 1'b0, 1'b0);
        hold_requests++;
        for (int k = 0; k < 40; k++) send_byte("a", 1'b0);
        send_byte(CH_LF, 1'b1);

        // Random part: sixteen rounds of at least fifty bytes each, walking through
        // the idle phases and a range of setups with the length extremes and
        // all-zero and all-ones patterns early on. A round sometimes leaves its
        // data open, so the next setup takes effect in the middle of a search.
        for (int round = 0; round < 16; round++) begin
            set_idling(round % 4);
            pat = random_pattern();
            case (round)
                0: len = 4'd1;
                1: len = 4'd8;
                2: len = 4'd0;
                3: len = 4'd15;
                4: begin pat = '1; len = 4'd8; end
                5: begin pat = '0; len = 4'd3; end
                default: len = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                         : 4'($urandom_range(1, 8));
            endcase
            configure(pat, len, 1'($urandom_range(1)), $urandom_range(3) == 0,
                      $urandom_range(3) == 0);
            items = 0;
            while (items < 50) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
                send_stream(n, !((items + n >= 50) && ($urandom_range(3) == 0)));
                items += n;
            end
        end

        // Drain: wait for every awaited result, bounded, then a little longer
        // to catch anything the block sends that was never expected.
        i_in_valid = 1'b0;
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (10) @(negedge i_clk);

        if (pending != 0) $error("%0d awaited results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
